[src/pipr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_pkg : shared types and constants for the point-in-polygon ray test
// field widths, outcome codes, item codes and the stored vertex layout
// ----------------------------------------------------------------------------
package pipr_pkg;

    localparam int LAT_W     = 31;
    localparam int LON_W     = 32;
    localparam int COUNT_W   = 7;
    localparam int INDEX_W   = 6;
    localparam int OUTCOME_W = 2;

    // smallest vertex count that makes a polygon
    localparam int MIN_POLY_VERTICES = 3;

    // item codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

    // outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_OUTSIDE    = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_INSIDE     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_NO_POLYGON = 2'd2;

    // one table entry
    typedef struct packed {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } t_vertex;

    // read slot marker travelling with the table read data
    typedef struct packed {
        logic valid;
        logic prime;  // first read of a walk: loads the wrap-around vertex only
    } t_edge_ctl;

endpackage

[src/pipr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_ram : generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pipr_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/pipr_edge_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_edge_unit : shared edge crossing unit
// three-stage pipeline, one polygon edge per cycle: differences, products,
// signed compare; flags each edge that crosses the ray
// ----------------------------------------------------------------------------
module pipr_edge_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pipr_pkg::t_edge_ctl               i_ctl,
    input  pipr_pkg::t_vertex                 i_vertex,
    input  logic signed [pipr_pkg::LAT_W-1:0] i_point_lat,
    input  logic signed [pipr_pkg::LON_W-1:0] i_point_lon,
    output logic                              o_toggle
);
    import pipr_pkg::*;

    localparam int AW = LAT_W + 1;   // latitude difference
    localparam int DW = LON_W + 1;   // longitude difference
    localparam int PW = AW + DW;     // full product

    // stage 1 inputs: current vertex i and previous vertex j
    t_vertex r_prev;

    logic                 w_cross;
    logic signed [AW-1:0] w_a;   // plat - lati
    logic signed [AW-1:0] w_b;   // latj - lati
    logic signed [DW-1:0] w_c;   // plon - loni
    logic signed [DW-1:0] w_d;   // lonj - loni

    assign w_cross = (i_vertex.lon > i_point_lon) != (r_prev.lon > i_point_lon);
    assign w_a = AW'(i_point_lat) - AW'(i_vertex.lat);
    assign w_b = AW'(r_prev.lat) - AW'(i_vertex.lat);
    assign w_c = DW'(i_point_lon) - DW'(i_vertex.lon);
    assign w_d = DW'(r_prev.lon) - DW'(i_vertex.lon);

    // stage 2 registers
    logic                 r_v2;
    logic                 r_cross2;
    logic signed [AW-1:0] r_a;
    logic signed [AW-1:0] r_b;
    logic signed [DW-1:0] r_c;
    logic signed [DW-1:0] r_d;

    // stage 3 registers
    logic                 r_v3;
    logic                 r_cross3;
    logic                 r_dneg3;
    logic signed [PW-1:0] r_lhs;
    logic signed [PW-1:0] r_rhs;

    logic signed [PW-1:0] w_lhs;
    logic signed [PW-1:0] w_rhs;
    logic                 w_below;

    assign w_lhs = PW'(r_a) * PW'(r_d);
    assign w_rhs = PW'(r_b) * PW'(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.valid && !i_ctl.prime;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prev <= i_vertex;
        end
        r_cross2 <= w_cross;
        r_a      <= w_a;
        r_b      <= w_b;
        r_c      <= w_c;
        r_d      <= w_d;
        r_cross3 <= r_cross2;
        r_dneg3  <= r_d[DW-1];
        r_lhs    <= w_lhs;
        r_rhs    <= w_rhs;
    end

    // point lies below the edge at the point's longitude
    assign w_below = r_dneg3 ? (r_lhs > r_rhs) : (r_lhs < r_rhs);
    assign o_toggle = r_v3 && r_cross3 && w_below;

endmodule

[src/point_in_polygon_ray_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_ray_test : crossing-number point-in-polygon test
// vertex table, walk sequencer and shared edge crossing unit
// ----------------------------------------------------------------------------
// usage
//   command channel: an item is taken on a rising edge with start high and
//   busy low. a write item (op = write) stores one vertex at vertex_index
//   (indices at or above MAX_VERTICES are dropped) and gives no result; it
//   leaves busy low, so the next item may follow at once
//   a test item (op = test) checks the point against the polygon made of
//   table entries 0 .. n-1, n being the configured count saturated to
//   MAX_VERTICES
//   result: o_outcome is shown for exactly one cycle with o_done high; the
//   receiver cannot hold it off. busy is low in that cycle, so a new item
//   can be taken alongside the result
//   timing: with n of zero, one or two the result comes in the cycle after
//   the transfer. otherwise the sequencer reads n+1 table entries, one per
//   cycle through the single table read port (the wrap-around vertex first),
//   then a drain state lets the edge unit flush its last edges before the
//   result comes
//   configuration: one register, the vertex count, written by a transfer on
//   the cfg channel; ready is high while no test is running
//   reset: synchronous, active low; clears the count and the sequencer. the
//   table is not cleared, entries read before being written are undefined
// ----------------------------------------------------------------------------
module point_in_polygon_ray_test #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // command channel
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_op,
    input  logic [pipr_pkg::INDEX_W-1:0]           i_vertex_index,
    input  logic signed [pipr_pkg::LAT_W-1:0]      i_coord_latitude,
    input  logic signed [pipr_pkg::LON_W-1:0]      i_coord_longitude,
    // result
    output logic                                   o_done,
    output logic [pipr_pkg::OUTCOME_W-1:0]         o_outcome,
    // configuration channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pipr_pkg::COUNT_W-1:0]           i_cfg_data
);
    import pipr_pkg::*;

    // table address, count and index widths
    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
    localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

    // cycles the edge unit needs after the last table read
    localparam int DRAIN_LEN = 3;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [COUNT_W-1:0]   r_vertex_count;
    logic [NW-1:0]        r_n, n_n;
    logic [NW-1:0]        r_issue, n_issue;
    logic [1:0]           r_drain, n_drain;
    logic [OUTCOME_W-1:0] r_outcome, n_outcome;
    t_edge_ctl            r_rd_ctl, n_rd_ctl;

    // test point, held for the whole walk
    logic signed [LAT_W-1:0] r_point_lat;
    logic signed [LON_W-1:0] r_point_lon;

    logic          w_accept;
    logic          w_toggle;
    logic          w_wr_ok;
    logic [XW-1:0] w_idx_ext;
    logic [CW-1:0] w_cnt_ext;
    logic [CW-1:0] w_n_full;
    logic [NW-1:0] w_n;
    logic [NW-1:0] w_raddr_full;
    t_vertex       w_wdata;
    t_vertex       w_rdata;

    // free to take an item when idle or while showing a result
    assign busy        = (r_state == S_WALK) || (r_state == S_DRAIN);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = !busy;
    assign o_done      = (r_state == S_DONE);
    assign o_outcome   = r_outcome;

    // vertex count saturated to the table depth
    assign w_cnt_ext = CW'(r_vertex_count);
    assign w_n_full  = (w_cnt_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : w_cnt_ext;
    assign w_n       = w_n_full[NW-1:0];

    // write side of the table
    assign w_idx_ext = XW'(i_vertex_index);
    assign w_wr_ok   = 32'(i_vertex_index) < 32'(MAX_VERTICES);
    assign w_wdata.lat = i_coord_latitude;
    assign w_wdata.lon = i_coord_longitude;

    // read order: last vertex first (edge j for i = 0), then 0 .. n-1
    assign w_raddr_full = (r_issue == '0) ? (r_n - NW'(1)) : (r_issue - NW'(1));

    pipr_ram #(
        .WIDTH ($bits(t_vertex)),
        .DEPTH (MAX_VERTICES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_op == OP_WRITE) && w_wr_ok),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr_full[AW-1:0]),
        .o_rdata (w_rdata)
    );

    pipr_edge_unit u_edge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_rd_ctl),
        .i_vertex    (w_rdata),
        .i_point_lat (r_point_lat),
        .i_point_lon (r_point_lon),
        .o_toggle    (w_toggle)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_issue  = r_issue;
        n_drain  = r_drain;
        // parity of crossings kept in the low outcome bit (outside -> inside)
        n_outcome = r_outcome ^ OUTCOME_W'(w_toggle);
        n_rd_ctl.valid = 1'b0;
        n_rd_ctl.prime = 1'b0;

        case (r_state)
            S_IDLE, S_DONE: begin
                n_state = S_IDLE;
                if (w_accept && (i_op == OP_TEST)) begin
                    n_n     = w_n;
                    n_issue = '0;
                    if (w_n == '0) begin
                        n_outcome = OUT_NO_POLYGON;
                        n_state   = S_DONE;
                    end else if (w_n < NW'(MIN_POLY_VERTICES)) begin
                        n_outcome = OUT_OUTSIDE;
                        n_state   = S_DONE;
                    end else begin
                        n_outcome = OUT_OUTSIDE;
                        n_state   = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // one table read per cycle
                n_rd_ctl.valid = 1'b1;
                n_rd_ctl.prime = (r_issue == '0);
                n_issue        = r_issue + NW'(1);
                if (r_issue == r_n) begin
                    n_state = S_DRAIN;
                    n_drain = 2'(DRAIN_LEN - 1);
                end
            end
            S_DRAIN: begin
                // let the edge unit flush its last edges
                if (r_drain == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_drain = r_drain - 2'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= '0;
            r_rd_ctl       <= '0;
            r_issue        <= '0;
            r_drain        <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_ctl <= n_rd_ctl;
            r_issue  <= n_issue;
            r_drain  <= n_drain;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_outcome <= n_outcome;
        if (w_accept && (i_op == OP_TEST)) begin
            r_point_lat <= i_coord_latitude;
            r_point_lon <= i_coord_longitude;
        end
    end

endmodule

[src/pipr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipr_port_checks : port-level checks for the point-in-polygon ray test
// watches the command, result and busy behaviour over time
// ----------------------------------------------------------------------------
module pipr_port_checks (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             i_op,
    input  logic                             o_done,
    input  logic [pipr_pkg::OUTCOME_W-1:0]   o_outcome
);
    import pipr_pkg::*;

    // a write transfer never makes the block busy
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_WRITE)) |=> !busy)
        else $error("write transfer left the block busy");

    // a test transfer is either running or answered in the next cycle
    a_test_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_TEST)) |=> (busy || o_done))
        else $error("test transfer neither started a walk nor answered");

    // a result only follows a walk or a test transfer
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || ($past(start) && ($past(i_op) == OP_TEST))))
        else $error("result strobe without a test");

    // only the three defined outcome codes appear
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_outcome == OUT_OUTSIDE) || (o_outcome == OUT_INSIDE)
                    || (o_outcome == OUT_NO_POLYGON)))
        else $error("undefined outcome code");

endmodule

bind point_in_polygon_ray_test pipr_port_checks u_pipr_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_op      (i_op),
    .o_done    (o_done),
    .o_outcome (o_outcome)
);
